/* rtl/core/isa_pkg.sv */
`default_nettype none
package isa_pkg;

  // command codes
  localparam logic [2:0] CMD_READ   = 3'd0;
  localparam logic [2:0] CMD_WRITE  = 3'd1;
  localparam logic [2:0] CMD_APPEND = 3'd2;
  localparam logic [2:0] CMD_INSERT = 3'd3;
  localparam logic [2:0] CMD_REMOVE = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // broadcast to every cell, at most one set per cycle
  typedef struct packed {
    logic wr;
    logic app;
    logic ins;
    logic rem;
  } isa_shift_t;

endpackage
`default_nettype wire

/* rtl/core/isa_ctrl.sv */
`default_nettype none
module isa_ctrl #(
  parameter int CAPACITY = 16,
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  wire logic               accept,
  input  wire logic [2:0]         cmd,
  input  wire logic [7:0]         position,
  input  wire logic [CW-1:0]      count,
  output isa_pkg::isa_shift_t     shift,
  output logic      [1:0]         status,
  output logic                    hit,
  output logic      [CW-1:0]      count_nxt
);
  import isa_pkg::*;

  localparam int CMPW = ((CW > 8) ? CW : 8) + 1;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic [CMPW-1:0] pos_ext;
  logic [CMPW-1:0] cnt_ext;
  logic            in_range;
  logic            ins_range;
  logic            full;

  assign pos_ext   = {{(CMPW-8){1'b0}}, position};
  assign cnt_ext   = {{(CMPW-CW){1'b0}}, count};
  assign in_range  = pos_ext < cnt_ext;
  assign ins_range = pos_ext <= cnt_ext;
  assign full      = count == CAP_C;

  always_comb begin
    shift     = '0;
    status    = ST_OK;
    hit       = 1'b0;
    count_nxt = count;
    unique case (cmd)
      CMD_READ: begin
        if (in_range) hit = 1'b1;
        else status = ST_RANGE;
      end
      CMD_WRITE: begin
        if (in_range) shift.wr = accept;
        else status = ST_RANGE;
      end
      CMD_APPEND: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          shift.app = accept;
          count_nxt = count + CW'(1);
        end
      end
      CMD_INSERT: begin
        // range error wins over full
        if (!ins_range) begin
          status = ST_RANGE;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          shift.ins = accept;
          count_nxt = count + CW'(1);
        end
      end
      CMD_REMOVE: begin
        if (in_range) begin
          hit       = 1'b1;
          shift.rem = accept;
          count_nxt = count - CW'(1);
        end else begin
          status = ST_RANGE;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/isa_cell.sv */
`default_nettype none
module isa_cell #(
  parameter int IDX       = 0,
  parameter int CW        = 5,
  parameter int WORD_BITS = 32
) (
  input  wire logic                   clk,
  input  wire isa_pkg::isa_shift_t    shift,
  input  wire logic [7:0]             position,
  input  wire logic [CW-1:0]          count,
  input  wire logic [WORD_BITS-1:0]   word_new,
  input  wire logic [WORD_BITS-1:0]   word_lower,
  input  wire logic [WORD_BITS-1:0]   word_upper,
  output logic      [WORD_BITS-1:0]   word,
  output logic      [WORD_BITS-1:0]   tap
);
  import isa_pkg::*;

  localparam logic [7:0]    IDX_P = IDX[7:0];
  localparam logic [CW-1:0] IDX_C = CW'(IDX);

  logic [WORD_BITS-1:0] word_r;
  logic [WORD_BITS-1:0] word_nxt;
  logic                 at_pos;

  assign at_pos = position == IDX_P;

  always_comb begin
    word_nxt = word_r;
    priority if (shift.wr) begin
      if (at_pos) word_nxt = word_new;
    end else if (shift.app) begin
      if (count == IDX_C) word_nxt = word_new;
    end else if (shift.ins) begin
      // cells above the slot move up by one
      if (at_pos) word_nxt = word_new;
      else if (IDX_P > position) word_nxt = word_lower;
    end else if (shift.rem) begin
      if (IDX_P >= position) word_nxt = word_upper;
    end else begin
      // idle cycle, the cell keeps its word
      word_nxt = word_r;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;
  assign tap  = at_pos ? word_r : '0;

endmodule
`default_nettype wire

/* rtl/core/indexed_shift_array_core.sv */
`default_nettype none
// Packed array of up to CAPACITY words held in a row of cells, one word per
// cell. Commands read, write, append, insert (upper words move up a cell)
// or remove (upper words move down a cell, removed word returned). Every
// cell updates in the same cycle from its neighbor, so one command of any
// kind is accepted per cycle while the output register is free; the
// result appears in the output register on the cycle after acceptance.
// The read path is an and-or select across all cells.
// After reset the count is zero and cell contents are don't-care, with no
// clearing pass; only words below the count are ever returned.
module indexed_shift_array_core #(
  parameter int CAPACITY  = 16,
  parameter int WORD_BITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // command channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         in_cmd,
  input  wire logic [7:0]         in_position,
  input  wire logic signed [31:0] in_word_in,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_word_out,
  output logic        [1:0]       out_status,
  output logic        [4:0]       out_count,
  output logic                    out_is_empty
);
  import isa_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  // fill count and handshake
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic          accept;
  logic          out_valid_r;

  // decode results
  isa_shift_t shift;
  logic [1:0] status;
  logic       hit;

  // cell row
  logic [WORD_BITS-1:0] words [CAPACITY];
  logic [WORD_BITS-1:0] taps  [CAPACITY];
  logic [WORD_BITS-1:0] rd_word;
  logic [WORD_BITS-1:0] word_new;
  logic [63:0]          w_ext;
  logic [63:0]          rd_ext;
  logic [31:0]          cnt_ext;

  // output register
  logic [31:0] word_out_r;
  logic [1:0]  status_r;
  logic [4:0]  count_out_r;
  logic        empty_r;

  // the result register blocks new items only while it holds an untaken item
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  // words live in the low WORD_BITS bits
  assign w_ext    = {32'd0, in_word_in};
  assign word_new = w_ext[WORD_BITS-1:0];

  isa_ctrl #(
    .CAPACITY (CAPACITY),
    .CW       (CW)
  ) u_ctrl (
    .accept    (accept),
    .cmd       (in_cmd),
    .position  (in_position),
    .count     (count_r),
    .shift     (shift),
    .status    (status),
    .hit       (hit),
    .count_nxt (count_nxt)
  );

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [WORD_BITS-1:0] lower;
    logic [WORD_BITS-1:0] upper;

    // ends of the row see no neighbor
    if (g == 0) begin : g_lo_end
      assign lower = '0;
    end else begin : g_lo
      assign lower = words[g-1];
    end
    if (g == CAPACITY - 1) begin : g_hi_end
      assign upper = '0;
    end else begin : g_hi
      assign upper = words[g+1];
    end

    isa_cell #(
      .IDX       (g),
      .CW        (CW),
      .WORD_BITS (WORD_BITS)
    ) u_cell (
      .clk        (clk),
      .shift      (shift),
      .position   (in_position),
      .count      (count_r),
      .word_new   (word_new),
      .word_lower (lower),
      .word_upper (upper),
      .word       (words[g]),
      .tap        (taps[g])
    );
  end

  // at most one cell matches the position, so or-ing the taps selects it
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_word = rd_word | taps[i];
    end
  end

  assign rd_ext  = 64'(rd_word);
  assign cnt_ext = 32'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded with each accepted item
  always_ff @(posedge clk) begin
    if (accept) begin
      word_out_r  <= hit ? rd_ext[31:0] : 32'd0;
      status_r    <= status;
      count_out_r <= cnt_ext[4:0];
      empty_r     <= count_nxt == '0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_word_out = $signed(word_out_r);
  assign out_status   = status_r;
  assign out_count    = count_out_r;
  assign out_is_empty = empty_r;

  // the fill count never passes the capacity
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C)
    else $error("fill count above capacity");

  // an accepted item always shows up in the result register
  a_result_follows : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted item produced no result");

  // a refused command leaves the count alone
  a_error_no_change : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && status != ST_OK) |=> count_r == $past(count_r))
    else $error("count changed on an error");

  // a full error is only reported with the array at capacity
  a_full_at_cap : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_FULL) |-> count_r == CAP_C)
    else $error("full status with room left");

  // empty flag of the shown result agrees with the stored count
  a_empty_match : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (empty_r == (count_r == '0)))
    else $error("empty flag disagrees with count");

endmodule
`default_nettype wire
